@@ hw/rtl/rmwp_pkg.sv @@
// Shared types and the single-precision adder for the row match window pre-accumulator.
package rmwp_pkg;

  localparam int ROW_W  = 15;
  localparam int BANK_W = 4;

  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  // Per-item fields that ride along the chain unchanged
  typedef struct packed {
    logic [1:0][ROW_W-1:0] row_index;
    logic [BANK_W-1:0]     bank;
    logic [1:0]            dummy;
    logic                  shared;
    logic                  tile_end;
    logic                  final_flag;
  } meta_t;

  // IEEE-754 single add, round to nearest even, subnormals kept.
  // NaN handling: first NaN operand is quieted and returned; inf - inf gives the default NaN.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y;
    logic [8:0]  ex, ey, e, lim;
    logic [23:0] mx, my;
    logic [8:0]  d;
    logic [4:0]  sh_amt;
    logic [50:0] sh;
    logic [26:0] al;
    logic [27:0] s;
    logic [4:0]  lz, amt;
    logic        found;
    logic [26:0] n;
    logic        rnd;
    logic [30:0] mag;
    logic [31:0] res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    x = a; y = b; ex = '0; ey = '0; e = '0; lim = '0; mx = '0; my = '0; d = '0;
    sh_amt = '0; sh = '0; al = '0; s = '0; lz = '0; amt = '0; found = 1'b0;
    n = '0; rnd = 1'b0; mag = '0; res = '0;
    if (a_nan) begin
      res = a | QNAN_BIT;
    end else if (b_nan) begin
      res = b | QNAN_BIT;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      res = DEFAULT_NAN;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = b;
    end else begin
      // larger magnitude first
      if (a[30:0] < b[30:0]) begin
        x = b; y = a;
      end
      ex = {1'b0, (x[30:23] == 8'd0) ? 8'd1 : x[30:23]};
      ey = {1'b0, (y[30:23] == 8'd0) ? 8'd1 : y[30:23]};
      mx = {x[30:23] != 8'd0, x[22:0]};
      my = {y[30:23] != 8'd0, y[22:0]};
      // align smaller operand, keep guard bits and sticky
      d      = ex - ey;
      sh_amt = (d > 9'd31) ? 5'd31 : d[4:0];
      sh     = {my, 27'd0} >> sh_amt;
      al     = sh[50:24] | {26'd0, |sh[23:0]};
      if (x[31] == y[31]) begin
        s = {1'b0, mx, 3'b000} + {1'b0, al};
      end else begin
        s = {1'b0, mx, 3'b000} - {1'b0, al};
      end
      if (s == 28'd0) begin
        res = {x[31] & y[31], 31'd0};
      end else begin
        if (s[27]) begin
          n = s[27:1] | {26'd0, s[0]};
          e = ex + 9'd1;
        end else begin
          for (int i = 26; i >= 0; i--) begin
            if (!found) begin
              if (s[i]) found = 1'b1;
              else lz = lz + 5'd1;
            end
          end
          lim = ex - 9'd1;
          amt = ({4'd0, lz} > lim) ? lim[4:0] : lz;
          n   = s[26:0] << amt;
          e   = ex - {4'd0, amt};
        end
        if (e >= 9'd255) begin
          res = {x[31], 8'hFF, 23'd0};
        end else begin
          rnd = n[2] & (n[1] | n[0] | n[3]);
          mag = {(n[26] ? e[7:0] : 8'd0), n[25:3]} + {30'd0, rnd};
          res = {x[31], mag};
        end
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/rmwp_window.sv @@
// Key/value windows for both lanes and the first stage of the accumulation chain.
module rmwp_window #(
  parameter int WINDOW    = 4,
  parameter int BANK_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       row_word_a,
  input  logic [31:0]                       value_a,
  input  logic [15:0]                       row_word_b,
  input  logic [31:0]                       value_b,
  input  logic                              shared_flag,
  input  logic                              tile_end,
  input  logic                              final_flag,
  output logic                              st_valid,
  input  logic                              st_ready,
  output logic [1:0][31:0]                  st_acc,
  output logic [1:0][WINDOW-1:0][31:0]      st_vals,
  output logic [1:0][WINDOW-1:0]            st_mask,
  output rmwp_pkg::meta_t                   st_meta
);

  localparam int KEY_W = 16 + BANK_BITS;
  localparam int BW    = (BANK_BITS < rmwp_pkg::BANK_W) ? BANK_BITS : rmwp_pkg::BANK_W;

  logic [1:0][WINDOW-1:0][KEY_W-1:0] key_r, key_nxt, key_sh;
  logic [1:0][WINDOW-1:0][31:0]      val_r, val_nxt, val_sh;
  logic [1:0][WINDOW-1:0]            mask;
  logic [1:0][15:0]                  row;
  logic [1:0][KEY_W-1:0]             key;
  logic [1:0][31:0]                  val;
  logic [BANK_BITS-1:0]              bank;
  logic                              take;
  logic                              valid_r;
  logic [1:0][31:0]                  acc_r;
  logic [1:0][WINDOW-1:0][31:0]      vals_r;
  logic [1:0][WINDOW-1:0]            mask_r;
  rmwp_pkg::meta_t                   meta_r, meta_nxt;

  assign in_ready = !valid_r || st_ready;
  assign take     = in_valid && in_ready;

  // row selection and key build
  always_comb begin
    bank   = shared_flag ? row_word_a[BANK_BITS-1:0] : '0;
    row[0] = shared_flag ? row_word_b : row_word_a;
    row[1] = row_word_b;
    val[0] = value_a;
    val[1] = value_b;
    for (int p = 0; p < 2; p++) begin
      key[p] = {shared_flag, row[p][14:0], bank};
    end
  end

  // shifted windows and match masks
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (k == WINDOW - 1) begin
          key_sh[p][k] = key[p];
          val_sh[p][k] = val[p];
        end else begin
          key_sh[p][k] = key_r[p][k+1];
          val_sh[p][k] = val_r[p][k+1];
        end
        mask[p][k] = (key_sh[p][k] == key[p]);
      end
    end
    key_nxt = tile_end ? '0 : key_sh;
    val_nxt = tile_end ? '0 : val_sh;
  end

  always_comb begin
    meta_nxt              = '0;
    meta_nxt.row_index[0] = row[0][14:0];
    meta_nxt.row_index[1] = row[1][14:0];
    meta_nxt.bank         = 4'(bank[BW-1:0]);
    meta_nxt.dummy[0]     = !row[0][15];
    meta_nxt.dummy[1]     = !row[1][15];
    meta_nxt.shared       = shared_flag;
    meta_nxt.tile_end     = tile_end;
    meta_nxt.final_flag   = final_flag;
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      val_r <= '0;
    end else if (take) begin
      key_r <= key_nxt;
      val_r <= val_nxt;
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int p = 0; p < 2; p++) begin
        acc_r[p] <= mask[p][0] ? val_sh[p][0] : 32'd0;
      end
      vals_r <= val_sh;
      mask_r <= mask;
      meta_r <= meta_nxt;
    end
  end

  assign st_valid = valid_r;
  assign st_acc   = acc_r;
  assign st_vals  = vals_r;
  assign st_mask  = mask_r;
  assign st_meta  = meta_r;

endmodule

@@ hw/rtl/rmwp_add_cell.sv @@
// One accumulation cell: adds one window entry per lane and hands on to the next cell.
module rmwp_add_cell #(
  parameter int WINDOW = 4,
  parameter int IDX    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [1:0][31:0]             up_acc,
  input  logic [1:0][WINDOW-1:0][31:0] up_vals,
  input  logic [1:0][WINDOW-1:0]       up_mask,
  input  rmwp_pkg::meta_t              up_meta,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [1:0][31:0]             dn_acc,
  output logic [1:0][WINDOW-1:0][31:0] dn_vals,
  output logic [1:0][WINDOW-1:0]       dn_mask,
  output rmwp_pkg::meta_t              dn_meta
);

  logic                         valid_r;
  logic [1:0][31:0]             acc_r, acc_nxt;
  logic [1:0][WINDOW-1:0][31:0] vals_r;
  logic [1:0][WINDOW-1:0]       mask_r;
  rmwp_pkg::meta_t              meta_r;
  logic                         take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  // non-matching entries add +0
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      acc_nxt[p] = rmwp_pkg::fp_add(up_acc[p], up_mask[p][IDX] ? up_vals[p][IDX] : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r  <= acc_nxt;
      vals_r <= up_vals;
      mask_r <= up_mask;
      meta_r <= up_meta;
    end
  end

  assign dn_valid = valid_r;
  assign dn_acc   = acc_r;
  assign dn_vals  = vals_r;
  assign dn_mask  = mask_r;
  assign dn_meta  = meta_r;

endmodule

@@ hw/rtl/row_match_window_preaccumulator_unit.sv @@
// Two-lane row match window pre-accumulator: one result per accepted item, IEEE single sums.
// The block takes one item per cycle while in_ready is high. Each item passes first through the window
// shift and key compare stage, then through the WINDOW-1 adder cells of the chain, each cell adding
// one window entry for both lanes in oldest-first order. Every stage holds its item until the next
// one takes it, so while a finished result waits at the output the chain keeps accepting only
// until its WINDOW stages are all full; then input ready drops until the output moves. Both windows
// clear after a tile-end item.
module row_match_window_preaccumulator_unit #(
  parameter int WINDOW    = 4,
  parameter int BANK_BITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_row_word_a,
  input  logic [31:0] in_value_a,
  input  logic [15:0] in_row_word_b,
  input  logic [31:0] in_value_b,
  input  logic        in_shared_flag,
  input  logic        in_tile_end_in,
  input  logic        in_final_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_row_index_a,
  output logic [3:0]  out_bank_a,
  output logic [31:0] out_sum_a,
  output logic        out_dummy_a,
  output logic [14:0] out_row_index_b,
  output logic [3:0]  out_bank_b,
  output logic [31:0] out_sum_b,
  output logic        out_dummy_b,
  output logic        out_shared_out,
  output logic        out_tile_end_out,
  output logic        out_final_out
);

  logic [WINDOW-1:0]                         st_valid, st_ready;
  logic [WINDOW-1:0][1:0][31:0]              st_acc;
  logic [WINDOW-1:0][1:0][WINDOW-1:0][31:0]  st_vals;
  logic [WINDOW-1:0][1:0][WINDOW-1:0]        st_mask;
  rmwp_pkg::meta_t                           st_meta [WINDOW];

  // window shift and first stage
  rmwp_window #(
    .WINDOW    (WINDOW),
    .BANK_BITS (BANK_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .row_word_a (in_row_word_a),
    .value_a    (in_value_a),
    .row_word_b (in_row_word_b),
    .value_b    (in_value_b),
    .shared_flag(in_shared_flag),
    .tile_end   (in_tile_end_in),
    .final_flag (in_final_in),
    .st_valid   (st_valid[0]),
    .st_ready   (st_ready[0]),
    .st_acc     (st_acc[0]),
    .st_vals    (st_vals[0]),
    .st_mask    (st_mask[0]),
    .st_meta    (st_meta[0])
  );

  // adder cell chain
  for (genvar g = 1; g < WINDOW; g++) begin : g_cell
    rmwp_add_cell #(
      .WINDOW (WINDOW),
      .IDX    (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(st_valid[g-1]),
      .up_ready(st_ready[g-1]),
      .up_acc  (st_acc[g-1]),
      .up_vals (st_vals[g-1]),
      .up_mask (st_mask[g-1]),
      .up_meta (st_meta[g-1]),
      .dn_valid(st_valid[g]),
      .dn_ready(st_ready[g]),
      .dn_acc  (st_acc[g]),
      .dn_vals (st_vals[g]),
      .dn_mask (st_mask[g]),
      .dn_meta (st_meta[g])
    );
  end

  // result channel
  assign st_ready[WINDOW-1] = out_ready;
  assign out_valid          = st_valid[WINDOW-1];
  assign out_row_index_a    = st_meta[WINDOW-1].row_index[0];
  assign out_bank_a         = st_meta[WINDOW-1].bank;
  assign out_sum_a          = st_acc[WINDOW-1][0];
  assign out_dummy_a        = st_meta[WINDOW-1].dummy[0];
  assign out_row_index_b    = st_meta[WINDOW-1].row_index[1];
  assign out_bank_b         = st_meta[WINDOW-1].bank;
  assign out_sum_b          = st_acc[WINDOW-1][1];
  assign out_dummy_b        = st_meta[WINDOW-1].dummy[1];
  assign out_shared_out     = st_meta[WINDOW-1].shared;
  assign out_tile_end_out   = st_meta[WINDOW-1].tile_end;
  assign out_final_out      = st_meta[WINDOW-1].final_flag;

endmodule
